>>> design/sbl_pkg.sv
// sbl_pkg: shared types and constants for the sorted byte list unit.
// No dependencies; used by sbl_ctrl, sbl_datapath and sorted_byte_list_unit.
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = 5;
   localparam int VALUE_W  = 8;
   localparam int STATUS_W = 3;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_DELETED   = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

>>> design/sorted_byte_list_unit.sv
// sorted_byte_list_unit: top level of the sorted signed-byte list.
// Depends on sbl_pkg, sbl_ctrl and sbl_datapath.
//
// Keeps up to 16 signed bytes in ascending order. An insert beat goes in
// front of the first entry that is not smaller; a delete beat removes the
// first equal entry. Each request beat yields one response beat with
// status, entry count and empty flag. An item is handled in two steps:
// capture of the request, then an execute step in which all entries are compared
// in parallel and the entry row, if written, shifts by one place. The execute step waits while the
// previous response is still stalled in the output register. The store
// needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_byte_list_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_command,
   input  wire logic signed [sbl_pkg::VALUE_W-1:0] req_item_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [sbl_pkg::STATUS_W-1:0]            rsp_status,
   output logic [sbl_pkg::COUNT_W-1:0]             rsp_entry_count,
   output logic                                    rsp_list_empty
);

   sbl_pkg::ctrl_cmd_type cmd;

   sbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sbl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_command),
      .req_item_value  (req_item_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_list_empty  (rsp_list_empty)
   );

endmodule

`default_nettype wire

>>> design/sbl_ctrl.sv
// sbl_ctrl: controller state machine for the sorted byte list unit.
// Depends on sbl_pkg; drives capture/commit commands to sbl_datapath.
`timescale 1ns / 1ps
`default_nettype none

module sbl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sbl_pkg::ctrl_cmd_type      cmd
);

   sbl_pkg::state_type state_ff;
   sbl_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbl_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sbl_pkg::S_EXEC;
            end
         end
         sbl_pkg::S_EXEC: begin
            if (out_free) begin
               state_in = sbl_pkg::S_IDLE;
            end
         end
         default: state_in = sbl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         sbl_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         sbl_pkg::S_EXEC: begin
            cmd.commit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/sbl_datapath.sv
// sbl_datapath: entry row, parallel compare, one-position shift and result register.
// Depends on sbl_pkg; commanded by sbl_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sbl_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sbl_pkg::ctrl_cmd_type         cmd,
   input  wire logic                          req_command,
   input  wire logic signed [sbl_pkg::VALUE_W-1:0] req_item_value,
   output logic [sbl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sbl_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                               rsp_list_empty
);

   localparam int N = sbl_pkg::CAPACITY;

   logic signed [sbl_pkg::VALUE_W-1:0] entry_ff [N];
   logic signed [sbl_pkg::VALUE_W-1:0] entry_in [N];
   logic [sbl_pkg::COUNT_W-1:0]        count_ff;
   logic [sbl_pkg::COUNT_W-1:0]        count_in;
   sbl_pkg::command_type               op_ff;
   logic signed [sbl_pkg::VALUE_W-1:0] value_ff;
   sbl_pkg::status_type                status_ff;
   sbl_pkg::status_type                status_in;
   logic [sbl_pkg::COUNT_W-1:0]        out_count_ff;
   logic                               out_empty_ff;
   logic [N-1:0]                       lt_vec;
   logic [N-1:0]                       eq_vec;
   logic [N-1:0]                       hit_le;
   logic                               full;
   logic                               empty;
   logic                               found;
   logic                               write_row;

   // per-entry compare and next value
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                               in_list;
      logic signed [sbl_pkg::VALUE_W-1:0] ins_val;
      logic signed [sbl_pkg::VALUE_W-1:0] del_val;

      assign in_list   = sbl_pkg::COUNT_W'(i) < count_ff;
      assign lt_vec[i] = in_list && (entry_ff[i] < value_ff);
      assign eq_vec[i] = in_list && (entry_ff[i] == value_ff);
      assign hit_le[i] = |(eq_vec & ({N{1'b1}} >> (N - 1 - i)));

      if (i == 0) begin : g_first
         assign ins_val = lt_vec[i] ? entry_ff[i] : value_ff;
      end else begin : g_rest
         assign ins_val = lt_vec[i]     ? entry_ff[i]   :
                          lt_vec[i-1]   ? value_ff      : entry_ff[i-1];
      end
      if (i == N - 1) begin : g_last
         assign del_val = entry_ff[i];
      end else begin : g_mid
         assign del_val = hit_le[i] ? entry_ff[i+1] : entry_ff[i];
      end
      assign entry_in[i] = (op_ff == sbl_pkg::CMD_INSERT) ? ins_val : del_val;
   end

   assign full  = count_ff == sbl_pkg::COUNT_W'(N);
   assign empty = count_ff == '0;
   assign found = |eq_vec;

   always_comb begin
      count_in  = count_ff;
      write_row = 1'b0;
      status_in = sbl_pkg::STAT_INSERTED;
      case (op_ff)
         sbl_pkg::CMD_INSERT: begin
            if (full) begin
               status_in = sbl_pkg::STAT_FULL;
            end else begin
               status_in = sbl_pkg::STAT_INSERTED;
               write_row = 1'b1;
               count_in  = count_ff + sbl_pkg::COUNT_W'(1);
            end
         end
         sbl_pkg::CMD_DELETE: begin
            if (empty) begin
               status_in = sbl_pkg::STAT_EMPTY;
            end else if (!found) begin
               status_in = sbl_pkg::STAT_NOT_FOUND;
            end else begin
               status_in = sbl_pkg::STAT_DELETED;
               write_row = 1'b1;
               count_in  = count_ff - sbl_pkg::COUNT_W'(1);
            end
         end
         default: status_in = sbl_pkg::STAT_INSERTED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= sbl_pkg::command_type'(req_command);
         value_ff <= req_item_value;
      end
      if (cmd.commit) begin
         status_ff    <= status_in;
         out_count_ff <= count_in;
         out_empty_ff <= count_in == '0;
         if (write_row) begin
            entry_ff <= entry_in;
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_list_empty  = out_empty_ff;

endmodule

`default_nettype wire
